### hw/rtl/vtyp_pkg.sv
// Shared constants, types and the arctangent step table for the vector to
// yaw/pitch pipeline. No dependencies.
`timescale 1ns / 1ps

package vtyp_pkg;

    // Rotation stages per arctangent pipeline (12..32)
    localparam int ROTATION_STEPS = 20;
    // Result bits of the square root, one per stage
    localparam int SQRT_STEPS = 32;

    // Field widths
    localparam int IN_W  = 24;
    localparam int DEG_W = 9;
    localparam int MAG_W = 48;  // operand width of the arctangent pipeline
    localparam int CW    = 51;  // signed rotation datapath, covers 1.647 gain
    localparam int AW    = 26;  // signed angle accumulator
    localparam int OA_W  = 23;  // clamped angle, 0..90 deg in 2^-16 units
    localparam int YA_W  = 24;  // yaw angle before wrap, 0..180 deg

    // Angles in 2^-16 degree
    localparam int ANG_SH  = 16;
    localparam int ANG_45  = 45 * 65536;
    localparam int ANG_90  = 90 * 65536;
    localparam int ANG_180 = 180 * 65536;

    localparam int DEG_90  = 90;
    localparam int DEG_270 = 270;
    localparam int DEG_360 = 360;

    // Pipeline depths
    localparam int SIDE_LEN = SQRT_STEPS + 3 + ROTATION_STEPS;
    localparam int YAW_LEN  = SQRT_STEPS + 2;

    // Arctangent shortcut codes
    typedef enum logic [1:0] {
        Q_RUN,    // normal rotation result
        Q_ZERO,   // opposite side zero: 0 deg
        Q_RIGHT,  // adjacent side zero: 90 deg
        Q_HALF    // equal sides: 45 deg
    } t_quad_e;

    // Per-item sideband that travels beside the datapath
    typedef struct packed {
        logic            neg_x;
        logic            neg_y;
        logic            neg_z;
        logic            z_gt;
        logic            xy_zero;
        logic [IN_W-1:0] az;
    } t_side;

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic signed [AW-1:0] atan_step(input int i);
        logic signed [AW-1:0] s;
        unique case (i)
            0:  s = 26'sd2949120;
            1:  s = 26'sd1740967;
            2:  s = 26'sd919879;
            3:  s = 26'sd466945;
            4:  s = 26'sd234379;
            5:  s = 26'sd117304;
            6:  s = 26'sd58666;
            7:  s = 26'sd29335;
            8:  s = 26'sd14668;
            9:  s = 26'sd7334;
            10: s = 26'sd3667;
            11: s = 26'sd1833;
            12: s = 26'sd917;
            13: s = 26'sd458;
            14: s = 26'sd229;
            15: s = 26'sd115;
            16: s = 26'sd57;
            17: s = 26'sd29;
            18: s = 26'sd14;
            19: s = 26'sd7;
            20: s = 26'sd4;
            21: s = 26'sd2;
            22: s = 26'sd1;
            default: s = 26'sd0;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/vtyp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vtyp_pkg.
`timescale 1ns / 1ps

module vtyp_sqrt (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [63:0] i_v,
    output logic [31:0] o_root
);

    logic [63:0] r_v   [vtyp_pkg::SQRT_STEPS];
    logic [63:0] r_res [vtyp_pkg::SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < vtyp_pkg::SQRT_STEPS; k++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] v_in, res_in, t;
            logic [63:0] n_v, n_res;

            if (k == 0) begin : g_first
                assign v_in   = i_v;
                assign res_in = '0;
            end else begin : g_next
                assign v_in   = r_v[k-1];
                assign res_in = r_res[k-1];
            end

            // trial subtract of res + bit
            always_comb begin
                t = res_in + BIT;
                if (v_in >= t) begin
                    n_v   = v_in - t;
                    n_res = (res_in >> 1) + BIT;
                end else begin
                    n_v   = v_in;
                    n_res = res_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_v[k]   <= n_v;
                    r_res[k] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[vtyp_pkg::SQRT_STEPS-1][31:0];

endmodule

### hw/rtl/vtyp_cordic.sv
// First-quadrant arctangent by a vectoring rotation pipeline, one step per
// stage, angle out in 2^-16 degree clamped to 0..90. Depends on vtyp_pkg.
`timescale 1ns / 1ps

module vtyp_cordic (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [vtyp_pkg::MAG_W-1:0]    i_a,   // adjacent side
    input  logic [vtyp_pkg::MAG_W-1:0]    i_b,   // opposite side
    output logic [vtyp_pkg::OA_W-1:0]     o_ang
);

    localparam int N    = vtyp_pkg::ROTATION_STEPS;
    localparam int CW   = vtyp_pkg::CW;
    localparam int AW   = vtyp_pkg::AW;
    localparam int OA_W = vtyp_pkg::OA_W;

    logic signed [CW-1:0] r_cx  [N];
    logic signed [CW-1:0] r_cy  [N];
    logic signed [AW-1:0] r_ang [N];
    vtyp_pkg::t_quad_e    r_code [N];

    vtyp_pkg::t_quad_e code_in;

    // shortcut cases, checked in this order
    always_comb begin
        priority if (i_b == '0) begin
            code_in = vtyp_pkg::Q_ZERO;
        end else if (i_a == '0) begin
            code_in = vtyp_pkg::Q_RIGHT;
        end else if (i_a == i_b) begin
            code_in = vtyp_pkg::Q_HALF;
        end else begin
            code_in = vtyp_pkg::Q_RUN;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            localparam logic signed [AW-1:0] STEP = vtyp_pkg::atan_step(i);
            logic signed [CW-1:0] cx, cy, dx, dy, ncy;
            logic signed [AW-1:0] ang;
            vtyp_pkg::t_quad_e    code;

            if (i == 0) begin : g_first
                assign cx   = CW'($signed({3'b000, i_a}));
                assign cy   = CW'($signed({3'b000, i_b}));
                assign ang  = '0;
                assign code = code_in;
            end else begin : g_next
                assign cx   = r_cx[i-1];
                assign cy   = r_cy[i-1];
                assign ang  = r_ang[i-1];
                assign code = r_code[i-1];
            end

            // shifts truncate toward zero; cx never goes negative
            assign ncy = -cy;
            assign dx  = cy[CW-1] ? -(ncy >>> i) : (cy >>> i);
            assign dy  = cx >>> i;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_code[i] <= code;
                    if (!cy[CW-1]) begin
                        r_cx[i]  <= cx + dx;
                        r_cy[i]  <= cy - dy;
                        r_ang[i] <= ang + STEP;
                    end else begin
                        r_cx[i]  <= cx - dx;
                        r_cy[i]  <= cy + dy;
                        r_ang[i] <= ang - STEP;
                    end
                end
            end
        end
    endgenerate

    // clamp and shortcut select
    logic signed [AW-1:0] last;
    assign last = r_ang[N-1];

    always_comb begin
        unique case (r_code[N-1])
            vtyp_pkg::Q_ZERO:  o_ang = '0;
            vtyp_pkg::Q_RIGHT: o_ang = OA_W'(vtyp_pkg::ANG_90);
            vtyp_pkg::Q_HALF:  o_ang = OA_W'(vtyp_pkg::ANG_45);
            default: begin
                if (last < 0) begin
                    o_ang = '0;
                end else if (last > AW'(vtyp_pkg::ANG_90)) begin
                    o_ang = OA_W'(vtyp_pkg::ANG_90);
                end else begin
                    o_ang = last[OA_W-1:0];
                end
            end
        endcase
    end

endmodule

### hw/rtl/vector_to_yaw_pitch_angles_top.sv
// Top level: direction vector in, whole-degree pitch and yaw out.
// Depends on vtyp_pkg, vtyp_sqrt, vtyp_cordic.
`timescale 1ns / 1ps
//
//  channel  dir  tdata fields (low bit up)                 width
//  s        in   x_pos[23:0] y_pos[47:24] z_pos[71:48]     72
//  m        out  pitch_deg[8:0] yaw_deg[17:9], zero pad    24
//
// One beat enters per cycle unless the pipeline holds; a result passes the
// input, square and sum registers, the 32-stage square root and the pitch
// rotation pipeline. The whole pipeline advances together and holds while
// the output register is full and not taken. Reset clears the valid bits only.

module vector_to_yaw_pitch_angles_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // x_pos, y_pos, z_pos
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // pitch_deg, yaw_deg
);

    localparam int SL    = vtyp_pkg::SIDE_LEN;
    localparam int YL    = vtyp_pkg::YAW_LEN;
    localparam int N     = vtyp_pkg::ROTATION_STEPS;
    localparam int SQ    = vtyp_pkg::SQRT_STEPS;
    localparam int IN_W  = vtyp_pkg::IN_W;
    localparam int DEG_W = vtyp_pkg::DEG_W;

    logic ce;
    logic [SL-1:0]        r_vld;
    vtyp_pkg::t_side      r_sd [SL];
    logic [DEG_W-1:0]     r_yw [YL];
    logic [IN_W-1:0]      r_ax, r_ay;
    logic [2*IN_W-1:0]    r_sqx, r_sqy;
    logic [63:0]          r_sum;
    logic                 r_out_vld;
    logic [DEG_W-1:0]     r_pitch, r_yaw;

    // whole pipe moves when the output slot is free or being taken
    assign ce         = !r_out_vld || i_m_tready;
    assign o_s_tready = ce;

    // input stage: magnitudes and signs
    logic signed [IN_W-1:0] x, y, z;
    vtyp_pkg::t_side        n_sd;
    assign x = i_s_tdata[23:0];
    assign y = i_s_tdata[47:24];
    assign z = i_s_tdata[71:48];

    always_comb begin
        n_sd.neg_x   = x[IN_W-1];
        n_sd.neg_y   = y[IN_W-1];
        n_sd.neg_z   = z[IN_W-1];
        n_sd.z_gt    = !z[IN_W-1] && (z != '0);
        n_sd.xy_zero = (x == '0) && (y == '0);
        n_sd.az      = z[IN_W-1] ? IN_W'(-z) : IN_W'(z);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_vld     <= {r_vld[SL-2:0], i_s_tvalid};
            r_out_vld <= r_vld[SL-1];
        end
    end

    // sideband line and magnitude/square stages
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sd[0] <= n_sd;
            for (int k = 1; k < SL; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_ax  <= x[IN_W-1] ? IN_W'(-x) : IN_W'(x);
            r_ay  <= y[IN_W-1] ? IN_W'(-y) : IN_W'(y);
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sum <= 64'({1'b0, r_sqx} + {1'b0, r_sqy}) << 16;
        end
    end

    // horizontal magnitude
    logic [31:0] root;
    vtyp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_v    (r_sum),
        .o_root (root)
    );

    // yaw rotation on |x|<<24, |y|<<24
    logic [vtyp_pkg::OA_W-1:0] yaw_a;
    vtyp_cordic u_yaw (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_a   ({r_ax, 24'd0}),
        .i_b   ({r_ay, 24'd0}),
        .o_ang (yaw_a)
    );

    // pitch rotation on r<<24 (root<<16), |z|<<24
    logic [vtyp_pkg::OA_W-1:0] pitch_a;
    vtyp_cordic u_pitch (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_a   ({root, 16'd0}),
        .i_b   ({r_sd[SQ+2].az, 24'd0}),
        .o_ang (pitch_a)
    );

    // yaw to whole degrees, then hold until pitch catches up
    vtyp_pkg::t_side            ys;
    logic [vtyp_pkg::YA_W-1:0]  yang;
    logic [7:0]                 yd;
    logic [DEG_W-1:0]           n_yaw;
    assign ys = r_sd[N];

    always_comb begin
        yang = ys.neg_x ? vtyp_pkg::YA_W'(vtyp_pkg::ANG_180) - vtyp_pkg::YA_W'(yaw_a)
                        : vtyp_pkg::YA_W'(yaw_a);
        yd   = yang[vtyp_pkg::YA_W-1:vtyp_pkg::ANG_SH];
        if (ys.xy_zero) begin
            n_yaw = '0;
        end else if (ys.neg_y && yd != '0) begin
            n_yaw = DEG_W'(vtyp_pkg::DEG_360) - DEG_W'(yd);
        end else begin
            n_yaw = DEG_W'(yd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_yw[0] <= n_yaw;
            for (int k = 1; k < YL; k++) begin
                r_yw[k] <= r_yw[k-1];
            end
        end
    end

    // pitch to whole degrees and output register
    vtyp_pkg::t_side  ps;
    logic [6:0]       pd;
    logic [DEG_W-1:0] n_pitch;
    assign ps = r_sd[SL-1];
    assign pd = pitch_a[vtyp_pkg::OA_W-1:vtyp_pkg::ANG_SH];

    always_comb begin
        if (ps.xy_zero) begin
            n_pitch = ps.z_gt ? DEG_W'(vtyp_pkg::DEG_90) : DEG_W'(vtyp_pkg::DEG_270);
        end else if (ps.neg_z && pd != '0) begin
            n_pitch = DEG_W'(vtyp_pkg::DEG_360) - DEG_W'(pd);
        end else begin
            n_pitch = DEG_W'(pd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pitch <= n_pitch;
            r_yaw   <= r_yw[YL-1];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_yaw, r_pitch};

    // checks
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_pitch < DEG_W'(vtyp_pkg::DEG_360)) &&
                       (r_yaw < DEG_W'(vtyp_pkg::DEG_360)))
        else $error("angle out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("valid survives reset");

    a_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ce && r_vld[SL-1] && ps.xy_zero |=> (r_yaw == '0) &&
            ((r_pitch == DEG_W'(vtyp_pkg::DEG_90)) || (r_pitch == DEG_W'(vtyp_pkg::DEG_270))))
        else $error("vertical vector gave wrong angles");

endmodule
